FILE: design/htrl_pkg.sv
`timescale 1ns / 1ps

package htrl_pkg;

   localparam int MAX_ROUTES  = 16;
   localparam int INDEX_BITS  = 4;
   localparam int COUNT_BITS  = 5;
   localparam int COLUMN_BITS = 16;
   localparam int HASH_BITS   = 32;
   localparam int CHAR_BITS   = 8;

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 56;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [HASH_BITS-1:0] HASH_BASIS = 32'h811c_9dc5;
   localparam logic [HASH_BITS-1:0] HASH_PRIME = 32'h0100_0193;

   // register indexes on the csr channel
   localparam logic CSR_ROUTE_COUNT    = 1'b0;
   localparam logic CSR_DEFAULT_COLUMN = 1'b1;

   // commands carried in req_tuser
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   typedef struct packed {
      logic take;     // input beat accepted this cycle
      logic compare;  // register hit vector against final hash
      logic pick;     // select column and load result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_stall;  // result register full and not being taken
   } dp_status_type;

endpackage

FILE: design/htrl_ctrl.sv
`timescale 1ns / 1ps

module htrl_ctrl
   import htrl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tlast,
   input  logic          req_tuser,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_PICK    = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.take    = 1'b0;
      cmd.compare = 1'b0;
      cmd.pick    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && req_tlast && (req_tuser == CMD_DISPATCH)) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_PICK;
         end
         S_PICK: begin
            if (!status.out_stall) begin
               cmd.pick = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_dispatch_end_compares: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && req_tlast && (req_tuser == CMD_DISPATCH)) |=> cmd.compare)
      else $error("dispatch end not followed by compare");

   a_compare_then_pick_state: assert property (@(posedge clock) disable iff (reset)
      cmd.compare |=> (state_ff == S_PICK) && !req_tready)
      else $error("compare not followed by pick state");

   a_no_pick_on_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> !status.out_stall)
      else $error("result loaded while output stalled");

   a_take_only_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> req_tready && !cmd.compare && !cmd.pick)
      else $error("beat taken outside idle");

endmodule

FILE: design/htrl_datapath.sv
`timescale 1ns / 1ps

module htrl_datapath
   import htrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   input  logic                     req_tuser,
   input  logic                     csr_valid,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [CHAR_BITS-1:0]   char_byte;
   logic                   has_char;
   logic [INDEX_BITS-1:0]  route_index;
   logic [COLUMN_BITS-1:0] column_in;

   assign char_byte   = req_tdata[CHAR_BITS-1:0];
   assign has_char    = req_tdata[CHAR_BITS];
   assign route_index = req_tdata[CHAR_BITS+INDEX_BITS:CHAR_BITS+1];
   assign column_in   = req_tdata[CHAR_BITS+INDEX_BITS+COLUMN_BITS:CHAR_BITS+INDEX_BITS+1];

   logic [COUNT_BITS-1:0]  route_count_ff;
   logic [COLUMN_BITS-1:0] default_column_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff    <= '0;
         default_column_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROUTE_COUNT:    route_count_ff    <= csr_data[COUNT_BITS-1:0];
            CSR_DEFAULT_COLUMN: default_column_ff <= csr_data[COLUMN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // running hash: one xor-multiply for each beat that carries a byte
   logic [HASH_BITS-1:0] running_hash_ff, running_hash_in;
   logic [HASH_BITS-1:0] folded;
   logic [HASH_BITS-1:0] final_hash_ff;

   always_comb begin
      folded = running_hash_ff;
      if (has_char) begin
         folded = (running_hash_ff ^ {{(HASH_BITS-CHAR_BITS){1'b0}}, char_byte}) * HASH_PRIME;
      end
      running_hash_in = running_hash_ff;
      if (cmd.take) begin
         running_hash_in = req_tlast ? HASH_BASIS : folded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= HASH_BASIS;
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && req_tlast) begin
         final_hash_ff <= folded;
      end
   end

   // route table, flops with no reset
   logic [HASH_BITS-1:0]   route_hash_ff   [MAX_ROUTES];
   logic [COLUMN_BITS-1:0] route_column_ff [MAX_ROUTES];

   always_ff @(posedge clock) begin
      if (cmd.take && req_tlast && (req_tuser == CMD_LOAD)
          && ({1'b0, route_index} < (INDEX_BITS+1)'(MAX_ROUTES))) begin
         route_hash_ff[route_index]   <= folded;
         route_column_ff[route_index] <= column_in;
      end
   end

   // hit vector, limited to the searched slots
   logic [COUNT_BITS-1:0] search_count;
   logic [MAX_ROUTES-1:0] hit_in, hit_ff;

   always_comb begin
      search_count = (route_count_ff > COUNT_BITS'(MAX_ROUTES))
                   ? COUNT_BITS'(MAX_ROUTES) : route_count_ff;
      for (int i = 0; i < MAX_ROUTES; i++) begin
         hit_in[i] = (route_hash_ff[i] == final_hash_ff) && (COUNT_BITS'(i) < search_count);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_ff <= hit_in;
      end
   end

   // lowest set bit wins
   logic [COLUMN_BITS-1:0] pick_column;

   always_comb begin
      pick_column = default_column_ff;
      for (int i = MAX_ROUTES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            pick_column = route_column_ff[i];
         end
      end
   end

   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.pick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         rsp_data_ff <= {{(RSP_DATA_BITS-HASH_BITS-1-COLUMN_BITS){1'b0}},
                         final_hash_ff, (|hit_ff), pick_column};
      end
   end

   assign status.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

endmodule

FILE: design/hashed_type_route_lookup_top.sv
`timescale 1ns / 1ps

// Hashed type route lookup.
// req_* is a stream of string beats, one byte at most per beat. req_tuser
// selects load (route name) or dispatch (packet type); req_tlast ends the
// string. Every byte is folded into one running FNV-1a hash.
// A load string ending stores hash and column at the given slot. A dispatch
// string ending compares the hash with slots 0 to route_count-1 (at most
// slot 15) and sends one beat on rsp_*: lowest matching slot's column, or
// default_column with matched clear, plus the final hash.
// csr_* writes route_count (index 0) and default_column (index 1); always
// ready, to be written only while the block is idle.
// Throughput: one beat a cycle while idle; after a dispatch-ending beat
// req_tready is low through the compare state and the column select state.
// The hit vector is registered on compare, the result register on select.
// The result sits in an output register; new beats are taken while it waits.
// If rsp_tready stays low a second dispatch result waits in the select step,
// and req_tready stays low until the register frees.
// Reset (synchronous) clears the hash to the offset basis, the registers to
// zero and the result register to empty; the route table is not cleared.
module hashed_type_route_lookup_top
   import htrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // char_byte[7:0], has_char[8], route_index[12:9], column_in[28:13], zero
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   // command[0]
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // column_out[15:0], matched[16], str_hash[48:17], zero
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   htrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   htrl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/route_lookup_checker.sv
`timescale 1ns / 1ps

module route_lookup_checker
   import htrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   input  logic                     req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       mismatch_total,
   output int                       lookups_pending
);

   typedef struct packed {
      logic [COLUMN_BITS-1:0] column;
      logic                   matched;
      logic [HASH_BITS-1:0]   hash;
   } lookup_type;

   lookup_type             lookups_due [$];
   logic [HASH_BITS-1:0]   hash_acc;
   logic [HASH_BITS-1:0]   slot_hash [MAX_ROUTES];
   logic [COLUMN_BITS-1:0] slot_column [MAX_ROUTES];
   logic [COUNT_BITS-1:0]  route_count;
   logic [COLUMN_BITS-1:0] default_column;
   int                     errors = 0;

   // lowest matching slot wins, so scan downwards and let the last hit stand
   function automatic lookup_type resolve_type(input logic [HASH_BITS-1:0] h);
      lookup_type r;
      int         n;
      r.column  = default_column;
      r.matched = 1'b0;
      r.hash    = h;
      n = (route_count > MAX_ROUTES) ? MAX_ROUTES : int'(route_count);
      for (int i = n - 1; i >= 0; i--) begin
         if (slot_hash[i] == h) begin
            r.matched = 1'b1;
            r.column  = slot_column[i];
         end
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      logic [HASH_BITS-1:0] h;
      lookup_type           want;
      if (reset) begin
         hash_acc       = HASH_BASIS;
         route_count    = '0;
         default_column = '0;
         lookups_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROUTE_COUNT)
               route_count = csr_data[COUNT_BITS-1:0];
            else
               default_column = csr_data[COLUMN_BITS-1:0];
         end
         if (req_tvalid && req_tready) begin
            h = hash_acc;
            if (req_tdata[8])
               h = (h ^ {24'b0, req_tdata[7:0]}) * HASH_PRIME;
            if (req_tlast) begin
               hash_acc = HASH_BASIS;
               // the command of the closing beat alone decides store or lookup
               if (req_tuser == CMD_LOAD) begin
                  slot_hash[req_tdata[12:9]]   = h;
                  slot_column[req_tdata[12:9]] = req_tdata[28:13];
               end else begin
                  lookups_due.push_back(resolve_type(h));
               end
            end else begin
               hash_acc = h;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (lookups_due.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = lookups_due.pop_front();
               check_field("column_out", 32'(want.column), 32'(rsp_tdata[15:0]));
               check_field("matched", 32'(want.matched), 32'(rsp_tdata[16]));
               check_field("str_hash", want.hash, rsp_tdata[48:17]);
            end
         end
      end
      mismatch_total  <= errors;
      lookups_pending <= lookups_due.size();
   end

endmodule

FILE: tb/hashed_type_route_lookup_top_tb.sv
`timescale 1ns / 1ps

module hashed_type_route_lookup_top_tb;
   import htrl_pkg::*;

   localparam int MAX_NAME     = 12;
   localparam int ITEM_TARGET  = 1750;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 300000;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic                     csr_index  = 1'b0;
   logic [CSR_DATA_BITS-1:0] csr_data   = '0;

   int mismatch_total;
   int lookups_pending;

   // string being sent, and the name held in each route slot
   logic [7:0] str_buf [MAX_NAME];
   int         str_len;
   logic [7:0] slot_name [MAX_ROUTES][MAX_NAME];
   int         slot_len [MAX_ROUTES];

   int items         = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   bit send_fast     = 1'b0;
   bit take_fast     = 1'b0;
   int cycle;

   hashed_type_route_lookup_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   route_lookup_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_total  (mismatch_total),
      .lookups_pending (lookups_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (cycle = 0; cycle < CYCLE_LIMIT; cycle++) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stalls, fast stretches, and the long hold-off on request
   initial begin
      int stall;
      forever begin
         if (holds_done < hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end
         if ($urandom_range(0, 29) == 0) take_fast = !take_fast;
         stall = take_fast ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_beat(input logic cmd, input logic [7:0] ch, input logic has,
                            input logic fin, input logic [3:0] idx,
                            input logic [15:0] col);
      int gap;
      gap = send_fast ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= fin;
      req_tdata  <= {3'b000, col, idx, has, ch};
      do @(posedge clock); while (!req_tready);
      if (has || fin) items++;
   endtask

   // str_buf as one string; closing beat is either the last byte or a bare end beat
   task automatic send_string(input logic cmd, input logic [3:0] idx,
                              input logic [15:0] col);
      bit   end_apart;
      logic beat_cmd;
      end_apart = (str_len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < str_len; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_beat(1'($urandom), 8'($urandom), 1'b0, 1'b0, 4'($urandom), 16'($urandom));
         beat_cmd = ($urandom_range(0, 9) == 0) ? 1'($urandom) : cmd;
         if (i == str_len - 1 && !end_apart)
            send_beat(cmd, str_buf[i], 1'b1, 1'b1, idx, col);
         else
            send_beat(beat_cmd, str_buf[i], 1'b1, 1'b0, 4'($urandom), 16'($urandom));
      end
      if (end_apart) send_beat(cmd, 8'($urandom), 1'b0, 1'b1, idx, col);
   endtask

   function automatic int name_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_NAME)
                                         : $urandom_range(0, 6);
   endfunction

   function automatic void make_name(input int len);
      str_len = len;
      for (int i = 0; i < len; i++)
         str_buf[i] = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
   endfunction

   function automatic void copy_name(input int src);
      str_len = slot_len[src];
      for (int i = 0; i < str_len; i++) str_buf[i] = slot_name[src][i];
   endfunction

   task automatic load_current(input int slot, input logic [15:0] col);
      slot_len[slot] = str_len;
      for (int i = 0; i < str_len; i++) slot_name[slot][i] = str_buf[i];
      send_string(CMD_LOAD, 4'(slot), col);
   endtask

   // sometimes reuse another slot's name so the lowest-slot rule gets exercised
   task automatic load_route(input int slot, input logic [15:0] col);
      if ($urandom_range(0, 7) == 0)
         copy_name($urandom_range(0, MAX_ROUTES - 1));
      else
         make_name(name_length());
      load_current(slot, col);
   endtask

   task automatic dispatch_slot(input int slot);
      copy_name(slot);
      send_string(CMD_DISPATCH, 4'($urandom), 16'($urandom));
   endtask

   task automatic dispatch_name(input int len);
      make_name(len);
      send_string(CMD_DISPATCH, 4'($urandom), 16'($urandom));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lookups_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [COUNT_BITS-1:0] count,
                             input logic [COLUMN_BITS-1:0] dflt);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROUTE_COUNT;
      csr_data  <= 16'(count);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_DEFAULT_COLUMN;
      csr_data  <= dflt;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int                     phase;
      int                     strings;
      int                     r;
      logic [COUNT_BITS-1:0]  count;
      logic [COLUMN_BITS-1:0] dflt;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // table empty, count zero: empty string, zero byte and all-ones byte
      dispatch_name(0);
      str_len    = 1;
      str_buf[0] = 8'h00;
      send_string(CMD_DISPATCH, 4'h0, 16'h0000);
      str_buf[0] = 8'hFF;
      send_string(CMD_DISPATCH, 4'hF, 16'hFFFF);
      wait_idle();
      write_regs('0, 16'hFFFF);
      dispatch_name(5);

      // every slot written before any count above zero
      for (int s = 0; s < MAX_ROUTES; s++)
         load_route(s, (s == 0) ? 16'h0000 : (s == MAX_ROUTES - 1) ? 16'hFFFF
                                                                   : 16'($urandom));
      wait_idle();
      write_regs(COUNT_BITS'(MAX_ROUTES), 16'h0000);
      dispatch_slot(0);
      dispatch_slot(MAX_ROUTES - 1);
      dispatch_slot(7);
      dispatch_name(0);
      copy_name(4);
      load_current(9, 16'hA5A5);
      dispatch_slot(9);

      // count above the table size, then a count of one
      wait_idle();
      write_regs(5'd31, 16'h5A5A);
      dispatch_slot(MAX_ROUTES - 1);
      dispatch_name(3);
      wait_idle();
      write_regs(5'd1, 16'($urandom));
      dispatch_slot(0);
      dispatch_slot(1);

      phase = 0;
      while (items < ITEM_TARGET) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0:       count = '0;
            1:       count = COUNT_BITS'(MAX_ROUTES);
            2:       count = COUNT_BITS'($urandom_range(MAX_ROUTES + 1, 31));
            default: count = COUNT_BITS'($urandom_range(1, MAX_ROUTES));
         endcase
         if ($urandom_range(0, 3) == 0)
            dflt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         else
            dflt = 16'($urandom);
         write_regs(count, dflt);
         send_fast = ($urandom_range(0, 3) == 0);
         // in phase 1 the result side holds off while beats keep coming
         if (phase == 1) hold_requests++;
         strings = $urandom_range(30, 60);
         for (int n = 0; n < strings; n++) begin
            if ($urandom_range(0, 15) == 0) send_fast = !send_fast;
            r = $urandom_range(0, 99);
            if (r < 30)
               load_route($urandom_range(0, MAX_ROUTES - 1), 16'($urandom));
            else if (r < 85)
               dispatch_slot($urandom_range(0, MAX_ROUTES - 1));
            else
               dispatch_name(name_length());
         end
         phase++;
      end

      wait_idle();
      if (mismatch_total == 0 && lookups_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
